[src/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg: shared definitions for the ring buffer with search unit
// Sizes, request codes, back-end states and the command and result bundles.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // buffer geometry
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned LIM         = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // command queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // field widths
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned WANT_W  = 8;
  localparam int unsigned WHERE_W = 4;
  localparam int unsigned TOTAL_W = 5;

  // stream word widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_FIELD_W = DATA_W + WHERE_W + TOTAL_W + 1;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH       = 3'd0,
    REQ_READ       = 3'd1,
    REQ_FIND_FIRST = 3'd2,
    REQ_FIND_ALL   = 3'd3,
    REQ_LAST_N     = 3'd4
  } req_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_FETCH
  } state_e;

  // decoded command, want already saturated
  typedef struct packed {
    req_e               op;
    logic [DATA_W-1:0]  value;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   want;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [WHERE_W-1:0] where;
    logic               valid_res;
    logic               last;
    logic [TOTAL_W-1:0] total;
    logic               wrapped;
  } res_t;

endpackage

[src/rbs_front.sv]
// ----------------------------------------------------------------------------
// rbs_front: request decoder
// Unpacks incoming requests, drops unknown request types and saturates the
// fetch count before handing a command to the queue.
// ----------------------------------------------------------------------------
module rbs_front import rbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  input  logic [REQ_W-1:0]      s_kind_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output cmd_t                  q_cmd_o
);

  logic [DATA_W-1:0] value;
  logic [SLOT_W-1:0] slot;
  logic [WANT_W-1:0] want;
  logic              known;
  logic [31:0]       drop_cnt_q;
  logic [31:0]       drop_cnt_d;

  // field unpacking
  assign value = s_data_i[DATA_W-1:0];
  assign slot  = s_data_i[DATA_W+SLOT_W-1:DATA_W];
  assign want  = s_data_i[DATA_W+SLOT_W+WANT_W-1:DATA_W+SLOT_W];

  // classify the request type
  always_comb begin
    case (s_kind_i)
      REQ_PUSH, REQ_READ, REQ_FIND_FIRST, REQ_FIND_ALL, REQ_LAST_N: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // build the command
  always_comb begin
    q_cmd_o.op    = req_e'(s_kind_i);
    q_cmd_o.value = value;
    q_cmd_o.slot  = slot;
    if (32'(want) > 32'(LIM)) begin
      q_cmd_o.want = CNT_W'(LIM);
    end else begin
      q_cmd_o.want = CNT_W'(want);
    end
  end

  // unknown requests are taken and dropped
  assign s_ready_o = q_ready_i;
  assign q_valid_o = s_valid_i && known;

  // count of dropped requests, kept for debug visibility
  always_comb begin
    drop_cnt_d = drop_cnt_q;
    if (s_valid_i && s_ready_o && !known) begin
      drop_cnt_d = drop_cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_cnt_q <= '0;
    end else begin
      drop_cnt_q <= drop_cnt_d;
    end
  end

endmodule

[src/rbs_fifo.sv]
// ----------------------------------------------------------------------------
// rbs_fifo: command queue
// Short queue that decouples the request decoder from the sequencer.
// ----------------------------------------------------------------------------
module rbs_fifo import rbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[src/rbs_back.sv]
// ----------------------------------------------------------------------------
// rbs_back: buffer and sequencer
// Holds the byte store, write pointer and wrapped flag, and executes one
// command at a time, issuing one result per cycle into an output register while the sink accepts results.
// ----------------------------------------------------------------------------
module rbs_back import rbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  cmd_t q_cmd_i,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t m_res_o
);

  state_e            state_q, state_d;
  logic [DATA_W-1:0] store_q [DEPTH];
  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic              rolled_q, rolled_d;
  logic [DEPTH-1:0]  mask_q, mask_d;
  logic              first_q, first_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  found_q, found_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic              out_free;
  logic              res_we;
  res_t              res;
  logic              st_we;
  logic [ADDR_W-1:0] st_addr;
  logic [DATA_W-1:0] st_data;
  logic [DEPTH-1:0]  match_vec;
  logic [DEPTH-1:0]  lo_oh;
  logic [DEPTH-1:0]  rest;
  logic [ADDR_W-1:0] lo_idx;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  n_eff;
  logic [ADDR_W:0]   start_sum;
  logic [ADDR_W-1:0] start_idx;
  logic [ADDR_W-1:0] wptr_inc;
  logic [ADDR_W-1:0] idx_inc;
  logic [CNT_W-1:0]  found_inc;
  logic              find_last;

  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

  // parallel compare of every slot against the search byte
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i] = (store_q[i] == q_cmd_i.value);
    end
  end

  // lowest pending match
  assign lo_oh = mask_q & (~mask_q + DEPTH'(1));
  assign rest  = mask_q & ~lo_oh;
  always_comb begin
    lo_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        lo_idx = ADDR_W'(i);
      end
    end
  end

  // fetch count and oldest slot of the fetch window
  assign held  = rolled_q ? CNT_W'(DEPTH) : CNT_W'(wptr_q);
  assign n_eff = (q_cmd_i.want < held) ? q_cmd_i.want : held;
  always_comb begin
    start_sum = (ADDR_W+1)'(wptr_q) + (ADDR_W+1)'(DEPTH) - (ADDR_W+1)'(n_eff);
    if (32'(start_sum) >= DEPTH) begin
      start_idx = ADDR_W'(start_sum - (ADDR_W+1)'(DEPTH));
    end else begin
      start_idx = ADDR_W'(start_sum);
    end
  end

  // pointer increments with wrap
  assign wptr_inc  = (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + ADDR_W'(1);
  assign idx_inc   = (32'(idx_q) == DEPTH - 1) ? '0 : idx_q + ADDR_W'(1);
  assign found_inc = found_q + CNT_W'(1);
  assign find_last = first_q || (rest == '0) || (32'(found_inc) == MAX_RESULTS);

  // sequencer: next state and result selection
  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    rolled_d    = rolled_q;
    mask_d      = mask_q;
    first_d     = first_q;
    val_d       = val_q;
    found_d     = found_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    n_d         = n_q;
    q_ready_o   = 1'b0;
    res_we      = 1'b0;
    res         = '0;
    res.last    = 1'b1;
    res.wrapped = rolled_q;
    st_we       = 1'b0;
    st_addr     = wptr_q;
    st_data     = q_cmd_i.value;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_ready_o = 1'b1;
          case (q_cmd_i.op)
            REQ_PUSH: begin
              st_we         = 1'b1;
              wptr_d        = wptr_inc;
              if (wptr_inc == '0) begin
                rolled_d = 1'b1;
              end
              res_we        = 1'b1;
              res.data      = q_cmd_i.value;
              res.where     = WHERE_W'(wptr_q);
              res.valid_res = 1'b1;
              res.wrapped   = rolled_d;
            end
            REQ_READ: begin
              res_we = 1'b1;
              if (32'(q_cmd_i.slot) < DEPTH) begin
                res.data      = store_q[ADDR_W'(q_cmd_i.slot)];
                res.where     = WHERE_W'(q_cmd_i.slot);
                res.valid_res = 1'b1;
              end
            end
            REQ_FIND_FIRST, REQ_FIND_ALL: begin
              mask_d  = match_vec;
              first_d = (q_cmd_i.op == REQ_FIND_FIRST);
              val_d   = q_cmd_i.value;
              found_d = '0;
              state_d = ST_FIND;
            end
            REQ_LAST_N: begin
              if (n_eff == '0) begin
                res_we = 1'b1;
              end else begin
                idx_d   = start_idx;
                rem_d   = n_eff;
                n_d     = n_eff;
                state_d = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FIND: begin
        if (out_free) begin
          res_we = 1'b1;
          if (mask_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            res.data      = val_q;
            res.where     = WHERE_W'(lo_idx);
            res.valid_res = 1'b1;
            res.last      = find_last;
            res.total     = find_last ? TOTAL_W'(found_inc) : '0;
            found_d       = found_inc;
            mask_d        = rest;
            if (find_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      ST_FETCH: begin
        if (out_free) begin
          res_we        = 1'b1;
          res.data      = store_q[idx_q];
          res.where     = WHERE_W'(idx_q);
          res.valid_res = 1'b1;
          res.last      = (rem_q == CNT_W'(1));
          res.total     = res.last ? TOTAL_W'(n_q) : '0;
          idx_d         = idx_inc;
          rem_d         = rem_q - CNT_W'(1);
          if (res.last) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_we) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      rolled_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rolled_q    <= rolled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers of the current command
  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    first_q <= first_d;
    val_q   <= val_d;
    found_q <= found_d;
    idx_q   <= idx_d;
    rem_q   <= rem_d;
    n_q     <= n_d;
    out_q   <= out_d;
  end

  // byte store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (st_we) begin
      store_q[st_addr] <= st_data;
    end
  end

`ifndef SYNTHESIS
  // no command is taken while a multi-result command is still running
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !q_ready_o)
    else $error("command taken while sequencer busy");

  // an empty result is always final and carries no entry
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_we && !res.valid_res) |-> (res.last && res.data == '0 && res.where == '0))
    else $error("malformed empty result");

  // the wrapped flag never clears once set
  a_rolled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rolled_q |=> rolled_q)
    else $error("wrapped flag cleared");

  // the write pointer only moves on a push
  a_wptr_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_we |=> (wptr_q == $past(wptr_q)))
    else $error("write pointer moved without a push");

  // a fetch in progress always has entries left
  a_fetch_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (rem_q != '0))
    else $error("fetch running with nothing left");
`endif

endmodule

[src/ring_buffer_with_search_unit.sv]
// ----------------------------------------------------------------------------
// ring_buffer_with_search_unit: overwriting byte ring buffer with search
// Stream front end, command queue and sequencer around a 16-byte store.
// ----------------------------------------------------------------------------
// A 16-entry overwriting byte buffer with a sticky wrapped flag. Requests
// (tuser = type) push a byte, read a slot, find the first or all slots that
// hold a byte, or fetch the newest N bytes oldest first. The store resets to
// zero directly, so requests are taken right after reset. Timing: a taken
// request is registered in the command queue before the sequencer can take
// it, and each result is registered in the output stage. Push, read and an
// empty last-N answer give their result from ST_IDLE. Find first and find
// all go on to ST_FIND and give one result per match (find first only one;
// a miss gives one empty result); last-N goes on to ST_FETCH and gives one
// result per fetched byte. The back-end sequencer issues at most one result
// per cycle; a two-entry command queue lets new requests be taken while it
// works, and a registered output stage holds a result while the sink stalls.
module ring_buffer_with_search_unit import rbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // value[7:0], slot[11:8], want_count[19:12], zero pad[23:20]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [REQ_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // data[7:0], where[11:8], total[16:12], wrapped[17], zero pad[23:18]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // valid_res
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;
  res_t res;

  // request decoder
  rbs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_kind_i  (s_axis_tuser),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_cmd_o   (fq_cmd)
  );

  // command queue
  rbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_cmd_o    (qb_cmd)
  );

  // buffer and sequencer
  rbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qb_valid),
    .q_ready_o (qb_ready),
    .q_cmd_i   (qb_cmd),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  // result packing
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.wrapped, res.total, res.where, res.data};
  assign m_axis_tuser = res.valid_res;
  assign m_axis_tlast = res.last;

endmodule
